>>> src/mau_pkg.sv
// Package for the modular arithmetic unit: widths, operation codes, reset modulus.
// No dependencies.
`default_nettype none
package mau_pkg;
  localparam int unsigned ModW   = 31;
  localparam int unsigned OpW    = 32;
  localparam int unsigned ExpW   = 63;
  localparam int unsigned CodeW  = 3;
  localparam logic [ModW-1:0] ModReset = 31'd1000000007;

  typedef enum logic [CodeW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_POW = 3'd3,
    OP_INV = 3'd4,
    OP_DIV = 3'd5
  } op_e;

  // Request to the modular multiplier.
  typedef struct packed {
    logic            start;
    logic [ModW-1:0] x;
    logic [ModW-1:0] y;
  } mul_req_t;
endpackage
`default_nettype wire

>>> src/modular_arithmetic_unit.sv
// Modular arithmetic unit: add, subtract, multiply, power, inverse, divide mod m.
// Operands are first reduced with four passes of the shared bit-serial modular
// multiplier, which also serves multiply, power (63-bit exponent), inverse and
// divide. One item at a time; in_stall is high until the result transfer.
// Reset clears control state and loads modulus 1000000007.
// Depends on mau_pkg and mau_modmul.
`default_nettype none
module modular_arithmetic_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [mau_pkg::ModW-1:0]   cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [mau_pkg::CodeW-1:0]  operation_i,
  input  wire logic [mau_pkg::OpW-1:0]    operand_a_i,
  input  wire logic [mau_pkg::OpW-1:0]    operand_b_i,
  input  wire logic [mau_pkg::ExpW-1:0]   exponent_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [mau_pkg::ModW-1:0]        result_o
);
  localparam int unsigned W  = mau_pkg::ModW;
  localparam int unsigned EW = mau_pkg::ExpW;
  localparam int unsigned BW = $clog2(EW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RED_A, S_RED_B, S_DISPATCH, S_POW_MUL, S_POW_SQ, S_POW_NEXT,
    S_DIV_MUL, S_PLAIN_MUL, S_OUT
  } state_e;

  state_e                     state_q;
  logic [W-1:0]               mod_q;
  logic [mau_pkg::CodeW-1:0]  op_q;
  logic [mau_pkg::OpW-1:0]    ra_q, rb_q;
  logic [EW-1:0]              e_q;
  logic [W-1:0]               a_q, b_q, acc_q, sq_q;
  logic [BW-1:0]              bit_q;
  logic [W-1:0]               res_q;
  logic                       wait_q;
  logic                       red_hi_q;
  mau_pkg::mul_req_t          req;
  logic                       mdone;
  logic [W-1:0]               mprod;
  logic [W:0]                 sum;
  logic [W-1:0]               sum_r, diff;

  mau_modmul u_mul (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(req), .mod_i(mod_q),
    .done_o(mdone), .prod_o(mprod)
  );

  // Add and subtract of reduced operands.
  always_comb begin
    sum   = {1'b0, a_q} + {1'b0, b_q};
    sum_r = (sum >= {1'b0, mod_q}) ? W'(sum - {1'b0, mod_q}) : sum[W-1:0];
    diff  = (a_q >= b_q) ? a_q - b_q : W'({1'b0, a_q} + {1'b0, mod_q} - {1'b0, b_q});
  end

  // Reduction of a 32-bit operand v: the multiplier forms 1 * v[31:1] mod m, which walks
  // the bits of v[31:1] in Horner order and so reduces it fully, then doubles that.
  logic [W-1:0] half_red;
  logic [W-1:0] src_half;
  always_comb begin
    src_half = (state_q == S_RED_A) ? ra_q[mau_pkg::OpW-1:1] : rb_q[mau_pkg::OpW-1:1];
    half_red = src_half;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mod_q    <= mau_pkg::ModReset;
      wait_q   <= 1'b0;
      red_hi_q <= 1'b0;
      req      <= '0;
    end else begin
      req.start <= 1'b0;
      if (cfg_we_i) mod_q <= cfg_wdata_i;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q <= operation_i;
            ra_q <= operand_a_i;
            rb_q <= operand_b_i;
            e_q  <= exponent_i;
            if (mod_q < W'(2)) begin
              res_q   <= '0;
              state_q <= S_OUT;
            end else begin
              state_q  <= S_RED_A;
              wait_q   <= 1'b0;
              red_hi_q <= 1'b0;
            end
          end
        end
        // Reduce a 32-bit operand: first 1*(v>>1) mod m, then that*2 mod m,
        // then add the low bit with one conditional subtract.
        S_RED_A, S_RED_B: begin
          if (!wait_q) begin
            req.start <= 1'b1;
            req.x     <= red_hi_q ? acc_q : W'(1);
            req.y     <= red_hi_q ? W'(2) : half_red;
            wait_q    <= 1'b1;
          end else if (mdone) begin
            wait_q <= 1'b0;
            if (!red_hi_q) begin
              acc_q    <= mprod;
              red_hi_q <= 1'b1;
            end else begin
              red_hi_q <= 1'b0;
              if (state_q == S_RED_A) begin
                a_q     <= (({1'b0, mprod} + {{W{1'b0}}, ra_q[0]}) >= {1'b0, mod_q}) ?
                           W'({1'b0, mprod} + {{W{1'b0}}, ra_q[0]} - {1'b0, mod_q}) :
                           W'(mprod + W'(ra_q[0]));
                state_q <= S_RED_B;
              end else begin
                b_q     <= (({1'b0, mprod} + {{W{1'b0}}, rb_q[0]}) >= {1'b0, mod_q}) ?
                           W'({1'b0, mprod} + {{W{1'b0}}, rb_q[0]} - {1'b0, mod_q}) :
                           W'(mprod + W'(rb_q[0]));
                state_q <= S_DISPATCH;
              end
            end
          end
        end
        S_DISPATCH: begin
          acc_q <= W'(1);
          bit_q <= '0;
          case (op_q)
            mau_pkg::OP_ADD: begin res_q <= sum_r; state_q <= S_OUT; end
            mau_pkg::OP_SUB: begin res_q <= diff;  state_q <= S_OUT; end
            mau_pkg::OP_MUL: begin state_q <= S_PLAIN_MUL; end
            mau_pkg::OP_POW: begin sq_q <= a_q; state_q <= S_POW_MUL; end
            mau_pkg::OP_INV: begin
              sq_q <= a_q;
              e_q  <= EW'(mod_q - W'(2));
              if (a_q == '0) begin res_q <= '0; state_q <= S_OUT; end
              else state_q <= S_POW_MUL;
            end
            mau_pkg::OP_DIV: begin
              sq_q <= b_q;
              e_q  <= EW'(mod_q - W'(2));
              if (b_q == '0) begin res_q <= '0; state_q <= S_OUT; end
              else state_q <= S_POW_MUL;
            end
            default: begin res_q <= '0; state_q <= S_OUT; end
          endcase
        end
        // acc *= sq when the current exponent bit is set.
        S_POW_MUL: begin
          if (!e_q[0]) begin
            state_q <= S_POW_SQ;
          end else if (!wait_q) begin
            req.start <= 1'b1; req.x <= acc_q; req.y <= sq_q; wait_q <= 1'b1;
          end else if (mdone) begin
            acc_q <= mprod; wait_q <= 1'b0; state_q <= S_POW_SQ;
          end
        end
        S_POW_SQ: begin
          if (e_q[EW-1:1] == '0) begin
            state_q <= S_POW_NEXT;
          end else if (!wait_q) begin
            req.start <= 1'b1; req.x <= sq_q; req.y <= sq_q; wait_q <= 1'b1;
          end else if (mdone) begin
            sq_q <= mprod; wait_q <= 1'b0; state_q <= S_POW_NEXT;
          end
        end
        S_POW_NEXT: begin
          e_q   <= e_q >> 1;
          bit_q <= bit_q + 1'b1;
          if (e_q[EW-1:1] == '0 || bit_q == BW'(EW - 1)) begin
            if (op_q == mau_pkg::OP_DIV) state_q <= S_DIV_MUL;
            else begin res_q <= acc_q; state_q <= S_OUT; end
          end else state_q <= S_POW_MUL;
        end
        S_DIV_MUL: begin
          if (!wait_q) begin
            req.start <= 1'b1; req.x <= a_q; req.y <= acc_q; wait_q <= 1'b1;
          end else if (mdone) begin
            res_q <= mprod; wait_q <= 1'b0; state_q <= S_OUT;
          end
        end
        S_PLAIN_MUL: begin
          if (!wait_q) begin
            req.start <= 1'b1; req.x <= a_q; req.y <= b_q; wait_q <= 1'b1;
          end else if (mdone) begin
            res_q <= mprod; wait_q <= 1'b0; state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign result_o    = res_q;
endmodule
`default_nettype wire

>>> src/mau_modmul.sv
// Bit-serial modular multiplier: (x * y) mod m, one bit of y per cycle.
// Depends on mau_pkg. Also used as a reducer with x = 1, y = value.
`default_nettype none
module mau_modmul (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mau_pkg::mul_req_t      req_i,
  input  wire logic [mau_pkg::ModW-1:0] mod_i,
  output logic                        done_o,
  output logic [mau_pkg::ModW-1:0]    prod_o
);
  localparam int unsigned CntW = $clog2(mau_pkg::ModW + 1);

  logic                     busy_q, busy_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [mau_pkg::ModW-1:0] x_q, x_d, y_q, y_d, acc_q, acc_d;
  logic                     done_d;
  logic [mau_pkg::ModW:0]   dbl, dbl_r, add, add_r;

  // Horner step from the top bit: acc = 2*acc (+ x), each kept below m.
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, mod_i}) ? dbl - {1'b0, mod_i} : dbl;
    add   = dbl_r + {1'b0, x_q};
    add_r = (add >= {1'b0, mod_i}) ? add - {1'b0, mod_i} : add;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(mau_pkg::ModW);
      x_d    = req_i.x;
      y_d    = req_i.y;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = y_q[mau_pkg::ModW-1] ? add_r[mau_pkg::ModW-1:0] : dbl_r[mau_pkg::ModW-1:0];
      y_d   = {y_q[mau_pkg::ModW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;
endmodule
`default_nettype wire
